// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg: shared constants and types for the rotation matrix to quaternion unit
// Holds field widths and the pivot selector codes.
// ----------------------------------------------------------------------------
package rmq_pkg;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int ElemW = 16;

    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } pivot_t;
endpackage

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: Shepperd conversion of a 3x3 matrix
// Streams signed fixed point rotation matrices in and quaternions out.
// ----------------------------------------------------------------------------
// One matrix beat enters per cycle and one quaternion beat leaves per cycle
// while the output is not stalled. One stage forms the four trace values,
// one picks the pivot, then the square root runs one result bit per stage,
// and the three divisions run one quotient bit per stage side by side. The
// chain of restoring square root and restoring divider stages sets the
// depth. Every stage holds when the output is stalled, so a stall loses and
// repeats nothing.
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each, from bit 0)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // qx, qy, qz, qw (16 bits each, from bit 0), saturated at bit 64, zero pad
    output logic [71:0]  m_axis_tdata
);
    // trace values fit in 18 bits; b+one fits the wider of that and F+1 bits,
    // and (b+one)<<F needs one more bit plus F
    localparam int TW   = ElemW + 2;
    localparam int SumW = (TW > FRACTION_BITS + 1) ? TW : FRACTION_BITS + 1;
    localparam int RadW = SumW + 1 + FRACTION_BITS;
    localparam int SqW  = (RadW + 1) / 2;          // root bits
    localparam int BigW = SqW - 1;                  // big = root >> 1
    localparam int NW   = ElemW + 1;                // off-diagonal magnitude
    localparam int DenW = BigW + 2;                 // 4*big
    localparam int DvdW = NW + FRACTION_BITS + 1;   // 2*mag*2^F + den
    localparam int QW   = DvdW;                     // quotient bits (x2)
    localparam int RemW = DenW + 2;
    localparam int NST  = 3 + SqW + QW + 2;

    // advance all stages together when the output stage can move
    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [NST-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = vld_reg[NST-1];

    // ---------------- stage 1: unpack, traces, off-diagonals ---------------
    logic signed [ElemW-1:0] m [9];
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            m[i] = s_axis_tdata[i*ElemW +: ElemW];
        end
    end

    logic signed [TW-1:0] t_reg [4];
    logic signed [NW-1:0] d_reg [6]; // 12-21, 20-02, 01-10, 01+10, 20+02, 12+21
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0] <= TW'(m[0]) + TW'(m[4]) + TW'(m[8]);
            t_reg[1] <= TW'(m[0]) - TW'(m[4]) - TW'(m[8]);
            t_reg[2] <= TW'(m[4]) - TW'(m[0]) - TW'(m[8]);
            t_reg[3] <= TW'(m[8]) - TW'(m[0]) - TW'(m[4]);
            d_reg[0] <= NW'(m[5]) - NW'(m[7]);
            d_reg[1] <= NW'(m[6]) - NW'(m[2]);
            d_reg[2] <= NW'(m[1]) - NW'(m[3]);
            d_reg[3] <= NW'(m[1]) + NW'(m[3]);
            d_reg[4] <= NW'(m[6]) + NW'(m[2]);
            d_reg[5] <= NW'(m[5]) + NW'(m[7]);
        end
    end

    // ---------------- stage 2: pick pivot, route numerators ----------------
    pivot_t               sel;
    logic signed [TW-1:0] best;
    always_comb
    begin
        best = t_reg[0];
        sel  = SEL_W;
        if (t_reg[1] > best)
        begin
            best = t_reg[1];
            sel  = SEL_X;
        end
        if (t_reg[2] > best)
        begin
            best = t_reg[2];
            sel  = SEL_Y;
        end
        if (t_reg[3] > best)
        begin
            best = t_reg[3];
            sel  = SEL_Z;
        end
    end

    // numerators ordered x, y, z, w; the pivot slot is unused
    logic signed [NW-1:0] n_next [4];
    always_comb
    begin
        unique case (sel)
            SEL_W:   n_next = '{d_reg[0], d_reg[1], d_reg[2], '0};
            SEL_X:   n_next = '{'0, d_reg[3], d_reg[4], d_reg[0]};
            SEL_Y:   n_next = '{d_reg[3], '0, d_reg[5], d_reg[1]};
            default: n_next = '{d_reg[4], d_reg[5], '0, d_reg[2]};
        endcase
    end

    logic [RadW-1:0]      rad_reg;
    pivot_t               sel_reg [2:NST-1];
    logic signed [NW-1:0] n_reg [2:SqW+3][4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg <= (RadW'(best) + (RadW'(1) << FRACTION_BITS)) << FRACTION_BITS;
            sel_reg[2] <= sel;
            n_reg[2]   <= n_next;
            for (int s = 3; s < NST; s++)
            begin
                sel_reg[s] <= sel_reg[s-1];
            end
            for (int s = 3; s <= SqW + 3; s++)
            begin
                n_reg[s] <= n_reg[s-1];
            end
        end
    end

    // ---------------- square root, one bit per stage -----------------------
    localparam int RadP = 2 * SqW;
    logic [RadP-1:0] sq_v_reg [SqW+1];
    logic [SqW-1:0]  sq_q_reg [SqW+1];
    logic [SqW+1:0]  sq_r_reg [SqW+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_v_reg[0] <= RadP'(rad_reg);
            sq_q_reg[0] <= '0;
            sq_r_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SqW; k++)
    begin : g_sqrt
        logic [SqW+2:0] rs;
        logic [SqW+2:0] tr;
        always_comb
        begin
            rs = {sq_r_reg[k][SqW:0], sq_v_reg[k][RadP-1 -: 2]};
            tr = {1'b0, sq_q_reg[k], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k] << 2;
                if (rs >= tr)
                begin
                    sq_r_reg[k+1] <= (SqW+2)'(rs - tr);
                    sq_q_reg[k+1] <= {sq_q_reg[k][SqW-2:0], 1'b1};
                end
                else
                begin
                    sq_r_reg[k+1] <= (SqW+2)'(rs);
                    sq_q_reg[k+1] <= {sq_q_reg[k][SqW-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- division setup ---------------------------------------
    // q = (2*mag*2^F + den) / (2*den) gives round half away from zero
    logic [BigW-1:0] big_reg  [QW+1];
    logic [DvdW-1:0] dv_n_reg [3][QW+1];
    logic [QW-1:0]   dv_q_reg [3][QW+1];
    logic [RemW-1:0] dv_r_reg [3][QW+1];
    logic [2:0]      neg_reg  [QW+1];
    logic [1:0]      slot [3];
    always_comb
    begin
        unique case (sel_reg[SqW+3])
            SEL_W:   slot = '{2'd0, 2'd1, 2'd2};
            SEL_X:   slot = '{2'd1, 2'd2, 2'd3};
            SEL_Y:   slot = '{2'd0, 2'd2, 2'd3};
            default: slot = '{2'd0, 2'd1, 2'd3};
        endcase
    end

    logic [BigW-1:0] big_w;
    assign big_w = sq_q_reg[SqW][SqW-1:1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            big_reg[0] <= big_w;
            for (int j = 0; j < 3; j++)
            begin
                logic signed [NW-1:0] nv;
                logic [NW-1:0]        mg;
                nv = n_reg[SqW+3][slot[j]];
                mg = nv[NW-1] ? NW'(-nv) : NW'(nv);
                neg_reg[0][j]   <= nv[NW-1];
                dv_n_reg[j][0]  <= (DvdW'(mg) << (FRACTION_BITS + 1)) +
                                   DvdW'({big_w, 2'b00});
                dv_q_reg[j][0]  <= '0;
                dv_r_reg[j][0]  <= '0;
            end
            for (int s = 1; s < QW + 1; s++)
            begin
                big_reg[s] <= big_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic [RemW-1:0] rs;
            logic [RemW-1:0] dd;
            always_comb
            begin
                rs = {dv_r_reg[j][k][RemW-2:0], dv_n_reg[j][k][DvdW-1]};
                dd = RemW'({big_reg[k], 3'b000});
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_n_reg[j][k+1] <= dv_n_reg[j][k] << 1;
                    if (rs >= dd)
                    begin
                        dv_r_reg[j][k+1] <= rs - dd;
                        dv_q_reg[j][k+1] <= {dv_q_reg[j][k][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_r_reg[j][k+1] <= rs;
                        dv_q_reg[j][k+1] <= {dv_q_reg[j][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- output: place, sign, saturate ------------------------
    function automatic logic [16:0] sat_u(input logic [QW-1:0] q, input logic ng);
        logic [15:0] v;
        logic        s;
        begin
            s = 1'b0;
            if (ng)
            begin
                if (q > QW'(32768))
                begin
                    v = 16'h8000;
                    s = 1'b1;
                end
                else v = 16'(-q);
            end
            else
            begin
                if (q > QW'(32767))
                begin
                    v = 16'h7FFF;
                    s = 1'b1;
                end
                else v = q[15:0];
            end
            sat_u = {s, v};
        end
    endfunction

    logic [16:0] o [4];
    logic [16:0] bq;
    logic [1:0]  oslot [3];
    pivot_t      psel;
    assign psel = sel_reg[NST-1];
    always_comb
    begin
        bq = (big_reg[QW] > BigW'(32767)) ? 17'h17FFF : {1'b0, 16'(big_reg[QW])};
        unique case (psel)
            SEL_W:   oslot = '{2'd0, 2'd1, 2'd2};
            SEL_X:   oslot = '{2'd1, 2'd2, 2'd3};
            SEL_Y:   oslot = '{2'd0, 2'd2, 2'd3};
            default: oslot = '{2'd0, 2'd1, 2'd3};
        endcase
        for (int i = 0; i < 4; i++)
        begin
            o[i] = bq;
        end
        for (int j = 0; j < 3; j++)
        begin
            o[oslot[j]] = sat_u(dv_q_reg[j][QW], neg_reg[QW][j]);
        end
    end

    logic [71:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= {7'd0, o[0][16] | o[1][16] | o[2][16] | o[3][16],
                        o[3][15:0], o[2][15:0], o[1][15:0], o[0][15:0]};
        end
    end
    assign m_axis_tdata = out_reg;
endmodule
